>>> hdl/sprite_zbuffer_occlusion_span_core_defines.svh
// Assertion macros used by the checker file.
`ifndef SPRITE_ZBUFFER_OCCLUSION_SPAN_CORE_DEFINES_SVH
`define SPRITE_ZBUFFER_OCCLUSION_SPAN_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SZBO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SZBO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/szbo_pkg.sv
package szbo_pkg;

	// Default screen width in columns.
	localparam int SCREEN_WIDTH_DEF = 1024;

	// Field widths.
	localparam int COL_W   = 12;
	localparam int DEPTH_W = 32;
	localparam int LEFT_W  = 16;
	localparam int WID_W   = 14;
	localparam int TEXW_W  = 12;
	localparam int PROD_W  = WID_W + TEXW_W;
	localparam int DCNT_W  = 4;

	// Request command codes.
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // latch query fields
		logic store;    // write one column depth
		logic setup;    // compute scan range, clear span state
		logic scan;     // read one column, advance
		logic mul;      // load product into divider
		logic sel_end;  // 0: start column, 1: end column
		logic div_step; // one quotient bit
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic empty;     // no on-screen column
		logic scan_last; // last column being read
		logic found;     // some column visible
		logic div_done;  // last quotient bit this cycle
	} dp_sts_t;

endpackage

>>> hdl/szbo_stream_if.sv
// Request channel: store or query.
interface szbo_req_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [szbo_pkg::COL_W-1:0]          column;
	logic [szbo_pkg::DEPTH_W-1:0]        wall_depth;
	logic signed [szbo_pkg::LEFT_W-1:0]  sprite_x;
	logic [szbo_pkg::WID_W-1:0]          sprite_width;
	logic [szbo_pkg::TEXW_W-1:0]         texture_width;
	logic [szbo_pkg::DEPTH_W-1:0]        sprite_depth;

	modport source (
		output valid, command, column, wall_depth, sprite_x, sprite_width,
			texture_width, sprite_depth,
		input  ready
	);
	modport sink (
		input  valid, command, column, wall_depth, sprite_x, sprite_width,
			texture_width, sprite_depth,
		output ready
	);
endinterface

// Result channel: visible span in texture columns.
interface szbo_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        visible;
	logic [szbo_pkg::TEXW_W-1:0] tex_start;
	logic [szbo_pkg::TEXW_W-1:0] tex_end;

	modport source (output valid, visible, tex_start, tex_end, input ready);
	modport sink (input valid, visible, tex_start, tex_end, output ready);
endinterface

>>> hdl/szbo_ctrl.sv
module szbo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_command,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output szbo_pkg::dp_cmd_t cmd,
	input  szbo_pkg::dp_sts_t sts
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SETUP = 9'b000000010,
		ST_SCAN  = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_MUL0  = 9'b000010000,
		ST_DIV0  = 9'b000100000,
		ST_MUL1  = 9'b001000000,
		ST_DIV1  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_nx;
	logic   req_acc;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);
	assign req_acc   = req_valid && req_ready;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && req_command == szbo_pkg::CMD_QUERY) state_nx = ST_SETUP;
			end
			ST_SETUP: begin
				state_nx = sts.empty ? ST_OUT : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nx = sts.found ? ST_MUL0 : ST_OUT;
			end
			ST_MUL0: state_nx = ST_DIV0;
			ST_DIV0: begin
				if (sts.div_done) state_nx = ST_MUL1;
			end
			ST_MUL1: state_nx = ST_DIV1;
			ST_DIV1: begin
				if (sts.div_done) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (rsp_ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	// Datapath commands
	always_comb begin
		cmd          = '0;
		cmd.load     = req_acc && req_command == szbo_pkg::CMD_QUERY;
		cmd.store    = req_acc && req_command == szbo_pkg::CMD_STORE;
		cmd.setup    = (state_q == ST_SETUP);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.mul      = (state_q == ST_MUL0) || (state_q == ST_MUL1);
		cmd.sel_end  = (state_q == ST_MUL1) || (state_q == ST_DIV1);
		cmd.div_step = (state_q == ST_DIV0) || (state_q == ST_DIV1);
	end

endmodule

>>> hdl/szbo_dp.sv
module szbo_dp #(
	parameter int SCREEN_WIDTH = szbo_pkg::SCREEN_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  szbo_pkg::dp_cmd_t                  cmd,
	output szbo_pkg::dp_sts_t                  sts,
	input  logic [szbo_pkg::COL_W-1:0]         column,
	input  logic [szbo_pkg::DEPTH_W-1:0]       wall_depth,
	input  logic signed [szbo_pkg::LEFT_W-1:0] sprite_x,
	input  logic [szbo_pkg::WID_W-1:0]         sprite_width,
	input  logic [szbo_pkg::TEXW_W-1:0]        texture_width,
	input  logic [szbo_pkg::DEPTH_W-1:0]       sprite_depth,
	output logic                               visible,
	output logic [szbo_pkg::TEXW_W-1:0]        tex_start,
	output logic [szbo_pkg::TEXW_W-1:0]        tex_end
);

	localparam int ADDR_W = $clog2(SCREEN_WIDTH);
	localparam int WID_W  = szbo_pkg::WID_W;
	localparam int TEXW_W = szbo_pkg::TEXW_W;
	localparam int PROD_W = szbo_pkg::PROD_W;
	localparam int DCNT_W = szbo_pkg::DCNT_W;
	localparam int SPAN_W = szbo_pkg::LEFT_W + 2;

	// Column depth store
	logic [szbo_pkg::DEPTH_W-1:0] mem [SCREEN_WIDTH];
	logic [szbo_pkg::DEPTH_W-1:0] rd_data_s1;
	logic                         rd_vld_s1;
	logic [WID_W-1:0]             c_s1;

	// Latched query
	logic signed [szbo_pkg::LEFT_W-1:0] left_q;
	logic [WID_W-1:0]                   wid_q;
	logic [TEXW_W-1:0]                  texw_q;
	logic [szbo_pkg::DEPTH_W-1:0]       sdepth_q;

	// Scan state
	logic [ADDR_W-1:0] addr_q;
	logic [WID_W-1:0]  c_q, c_end_q;
	logic              found_q;
	logic [WID_W-1:0]  first_q, last_q;

	// Divider
	logic [PROD_W-1:0] w_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [TEXW_W-1:0] start_q, end_q;

	// Range setup
	logic signed [SPAN_W-1:0] left_x, hi_full, c_lo, wid_x;
	logic                     left_neg, store_ok;

	assign left_neg = left_q[szbo_pkg::LEFT_W-1];
	assign left_x   = SPAN_W'(left_q);
	assign wid_x    = $signed({{(SPAN_W-WID_W){1'b0}}, wid_q});
	assign c_lo     = left_neg ? -left_x : '0;
	assign hi_full  = $signed(SPAN_W'(SCREEN_WIDTH)) - left_x;
	assign store_ok = {1'b0, column} < (szbo_pkg::COL_W+1)'(SCREEN_WIDTH);

	assign sts.empty     = (wid_x <= c_lo) || (hi_full <= c_lo);
	assign sts.scan_last = (c_q == c_end_q - WID_W'(1));
	// Includes the column still in the read register
	assign sts.found     = found_q || (rd_vld_s1 && rd_data_s1 >= sdepth_q);
	assign sts.div_done  = (dcnt_q == DCNT_W'(TEXW_W - 1));

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.store && store_ok) mem[column[ADDR_W-1:0]] <= wall_depth;
		if (cmd.scan) rd_data_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q   <= sprite_x;
			wid_q    <= sprite_width;
			texw_q   <= texture_width;
			sdepth_q <= sprite_depth;
		end
	end

	// Scan counters
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			addr_q  <= left_neg ? '0 : left_q[ADDR_W-1:0];
			c_q     <= c_lo[WID_W-1:0];
			c_end_q <= (hi_full < wid_x) ? hi_full[WID_W-1:0] : wid_q;
		end else if (cmd.scan) begin
			addr_q <= addr_q + ADDR_W'(1);
			c_q    <= c_q + WID_W'(1);
		end
		c_s1 <= c_q;
	end

	// Visibility tracking on the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.setup) found_q <= 1'b0;
			else if (rd_vld_s1 && rd_data_s1 >= sdepth_q) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_data_s1 >= sdepth_q) begin
			if (!found_q) first_q <= c_s1;
			last_q <= c_s1;
		end
	end

	// Multiply then restoring divide, one quotient bit a cycle
	logic [WID_W-1:0]  mul_op;
	logic [WID_W:0]    trial;
	logic              qbit;
	logic [WID_W-1:0]  rem_nx;

	assign mul_op = cmd.sel_end ? last_q + WID_W'(1) : first_q;
	assign trial  = w_q[PROD_W-1:TEXW_W-1];
	assign qbit   = trial >= {1'b0, wid_q};
	assign rem_nx = qbit ? WID_W'(trial - {1'b0, wid_q}) : trial[WID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.mul) dcnt_q <= '0;
		else if (cmd.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) w_q <= PROD_W'(mul_op) * PROD_W'(texw_q);
		else if (cmd.div_step) w_q <= {rem_nx, w_q[TEXW_W-2:0], qbit};
	end

	// Span results, cleared for an empty answer
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			start_q <= '0;
			end_q   <= '0;
		end else if (cmd.div_step && sts.div_done) begin
			if (cmd.sel_end) end_q <= {w_q[TEXW_W-2:0], qbit};
			else             start_q <= {w_q[TEXW_W-2:0], qbit};
		end
	end

	assign visible   = found_q;
	assign tex_start = start_q;
	assign tex_end   = end_q;

endmodule

>>> hdl/sprite_zbuffer_occlusion_span_core.sv
// Sprite occlusion span against a per-column wall depth buffer of SCREEN_WIDTH
// entries. A store request (command 0) writes one column depth; columns at or
// beyond SCREEN_WIDTH are dropped and no result is returned. A query request
// (command 1) returns one result: the sprite's columns are read from the depth
// memory one per cycle, over on-screen columns only, and a column is visible when
// its wall depth is not below the sprite depth. The first visible column and the
// one past the last are then scaled by texture_width / sprite_width with one
// shared 12-step restoring divider, in two passes, start then end. The single
// memory read port carries the scan. A hidden query skips the divider, and one
// with no on-screen column skips the scan as well. One request is in progress at
// a time. Columns must be written before a query reads them.
module sprite_zbuffer_occlusion_span_core #(
	parameter int SCREEN_WIDTH = szbo_pkg::SCREEN_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	szbo_req_if.sink    req,
	szbo_rsp_if.source  rsp
);

	szbo_pkg::dp_cmd_t cmd;
	szbo_pkg::dp_sts_t sts;

	szbo_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	szbo_dp #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.column        (req.column),
		.wall_depth    (req.wall_depth),
		.sprite_x      (req.sprite_x),
		.sprite_width  (req.sprite_width),
		.texture_width (req.texture_width),
		.sprite_depth  (req.sprite_depth),
		.visible       (rsp.visible),
		.tex_start     (rsp.tex_start),
		.tex_end       (rsp.tex_end)
	);

endmodule

>>> hdl/szbo_checker.sv
`include "sprite_zbuffer_occlusion_span_core_defines.svh"

module szbo_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_visible,
	input logic [szbo_pkg::TEXW_W-1:0] rsp_tex_start,
	input logic [szbo_pkg::TEXW_W-1:0] rsp_tex_end
);

	// A pending result stays offered
	`SZBO_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

	// Hidden sprite reports an empty span
	`SZBO_ASSERT_NOW(a_hidden_zero, clk, arst_n, rsp_valid && !rsp_visible, rsp_tex_start == '0 && rsp_tex_end == '0, "hidden span not zero")

	// No new request while a result is pending
	`SZBO_ASSERT_NOW(a_one_at_a_time, clk, arst_n, rsp_valid, !req_ready, "request taken with result pending")

	// A result never appears in the cycle after a request is taken
	`SZBO_ASSERT_NEXT(a_no_early_rsp, clk, arst_n, req_valid && req_ready, !rsp_valid, "result too early")

	// A result is not repeated right after it is taken
	`SZBO_ASSERT_NEXT(a_single_rsp, clk, arst_n, rsp_valid && rsp_ready, !rsp_valid, "result repeated")

endmodule

bind sprite_zbuffer_occlusion_span_core szbo_checker u_szbo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_visible   (rsp.visible),
	.rsp_tex_start (rsp.tex_start),
	.rsp_tex_end   (rsp.tex_end)
);

>>> sim/sprite_zbuffer_occlusion_span_core_tb.sv
`timescale 1ns / 1ps

module sprite_zbuffer_occlusion_span_core_tb;

	localparam int SCR_W   = szbo_pkg::SCREEN_WIDTH_DEF;
	localparam int COL_W   = szbo_pkg::COL_W;
	localparam int DEPTH_W = szbo_pkg::DEPTH_W;
	localparam int LEFT_W  = szbo_pkg::LEFT_W;
	localparam int WID_W   = szbo_pkg::WID_W;
	localparam int TEXW_W  = szbo_pkg::TEXW_W;
	// Column windows written up front at the two screen edges.
	localparam int FILL_LO = 320;
	localparam int FILL_HI = 192;
	// Longest query: a full on-screen scan plus two divider passes, with margin.
	localparam int SETTLE_CYCLES = 1200;
	// Long receiver hold-off that backs requests up behind one stuck query.
	localparam int HOLD_CYCLES = 400;
	// ~950 requests, each at most a full scan and two divider passes plus stalls, with wide margin.
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int RANDOM_PER_PACE = 100;
	localparam int MAX_REPORTS = 10;

	// Idle patterns used per phase.
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic                command;
		logic [COL_W-1:0]    column;
		logic [DEPTH_W-1:0]  wall_depth;
		logic [LEFT_W-1:0]   sprite_x;
		logic [WID_W-1:0]    sprite_width;
		logic [TEXW_W-1:0]   texture_width;
		logic [DEPTH_W-1:0]  sprite_depth;
	} depth_req_t;

	typedef struct packed {
		depth_req_t body;
		pace_t      pace;
		logic       drain_first;
		logic       hold_rx;
	} paced_req_t;

	typedef struct packed {
		logic              visible;
		logic [TEXW_W-1:0] tex_start;
		logic [TEXW_W-1:0] tex_end;
	} span_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	szbo_req_if req_ch ();
	szbo_rsp_if rsp_ch ();

	// Driven values, known from time zero.
	depth_req_t drv_req = '0;
	logic       drv_valid = 1'b0;
	logic       rsp_ready = 1'b0;
	logic       hold_kick = 1'b0;
	int         hold_left = 0;
	pace_t      cur_pace = PACE_FULL;

	// Shadow depth buffer and spans still owed by the block.
	logic [DEPTH_W-1:0] zdepth [SCR_W];
	paced_req_t         pending_reqs[$];
	span_t              owed_spans[$];
	int                 fault_cnt = 0;
	longint             cyc = 0;
	// Columns written by the queued stores so far.
	bit                 planned [SCR_W];

	assign req_ch.valid         = drv_valid;
	assign req_ch.command       = drv_req.command;
	assign req_ch.column        = drv_req.column;
	assign req_ch.wall_depth    = drv_req.wall_depth;
	assign req_ch.sprite_x      = drv_req.sprite_x;
	assign req_ch.sprite_width  = drv_req.sprite_width;
	assign req_ch.texture_width = drv_req.texture_width;
	assign req_ch.sprite_depth  = drv_req.sprite_depth;
	assign rsp_ch.ready         = rsp_ready;

	sprite_zbuffer_occlusion_span_core #(
		.SCREEN_WIDTH(SCR_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #6 clk = ~clk;

	// Visible span of one sprite against the shadow buffer.
	function automatic span_t occlusion_span(depth_req_t r);
		int first;
		int last;
		int sc;
		longint unsigned num;
		span_t s;
		first = -1;
		last = -1;
		s = '0;
		for (int c = 0; c < int'(r.sprite_width); c++) begin
			sc = int'($signed(r.sprite_x)) + c;
			if (sc < 0 || sc >= SCR_W)
				continue;
			if (zdepth[sc] < r.sprite_depth)
				continue;
			if (first < 0)
				first = c;
			last = c;
		end
		if (first >= 0) begin
			s.visible = 1'b1;
			num = longint'(first) * r.texture_width;
			s.tex_start = TEXW_W'(num / r.sprite_width);
			num = longint'(last + 1) * r.texture_width;
			s.tex_end = TEXW_W'(num / r.sprite_width);
		end
		return s;
	endfunction

	// Apply an accepted request: stores update the buffer, queries owe a span.
	task automatic record_request(depth_req_t r);
		if (r.command == szbo_pkg::CMD_STORE) begin
			if (r.column < SCR_W)
				zdepth[r.column] = r.wall_depth;
		end else begin
			owed_spans.push_back(occlusion_span(r));
		end
	endtask

	task automatic report_fault(string msg);
		fault_cnt++;
		if (fault_cnt <= MAX_REPORTS)
			$display("[%0t] %s", $time, msg);
	endtask

	// Mid-range depths give partial occlusion; some full-range and extremes.
	function automatic logic [DEPTH_W-1:0] pick_depth();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return 32'h0001_0000 + $urandom_range(32'h000F_0000);
		else if (sel < 85)
			return $urandom;
		else if (sel < 92)
			return '0;
		else
			return '1;
	endfunction

	function automatic depth_req_t store_of(int col, logic [DEPTH_W-1:0] dep);
		depth_req_t r;
		r = '0;
		r.command = szbo_pkg::CMD_STORE;
		r.column = COL_W'(col);
		r.wall_depth = dep;
		return r;
	endfunction

	function automatic depth_req_t query_of(int left, int wid, int texw,
			logic [DEPTH_W-1:0] dep);
		depth_req_t r;
		r = '0;
		r.command = szbo_pkg::CMD_QUERY;
		r.sprite_x = LEFT_W'(left);
		r.sprite_width = WID_W'(wid);
		r.texture_width = TEXW_W'(texw);
		r.sprite_depth = dep;
		return r;
	endfunction

	function automatic depth_req_t random_store();
		int col;
		col = ($urandom_range(99) < 10) ? int'($urandom_range(4095))
			: int'($urandom_range(SCR_W - 1));
		return store_of(col, pick_depth());
	endfunction

	// Mostly narrow sprites near the screen; a few wide or wild ones.
	function automatic depth_req_t random_query();
		int left;
		int wid;
		int texw;
		int unsigned sel;
		left = ($urandom_range(99) < 80) ? int'($urandom_range(SCR_W + 64)) - 64
			: int'($urandom_range(65535)) - 32768;
		sel = $urandom_range(99);
		if (sel < 85)
			wid = $urandom_range(150, 1);
		else if (sel < 90)
			wid = 0;
		else if (sel < 95)
			wid = $urandom_range(16383);
		else
			wid = $urandom_range(1100, 150);
		sel = $urandom_range(99);
		if (sel < 70)
			texw = $urandom_range(256, 1);
		else if (sel < 90)
			texw = $urandom_range(4095);
		else
			texw = 0;
		return query_of(left, wid, texw, pick_depth());
	endfunction

	// True when every on-screen column the query scans is already written.
	function automatic bit reads_written(depth_req_t r);
		int sc;
		for (int c = 0; c < int'(r.sprite_width); c++) begin
			sc = int'($signed(r.sprite_x)) + c;
			if (sc >= 0 && sc < SCR_W && !planned[sc])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Random query over written columns only; falls back to one off screen.
	function automatic depth_req_t safe_query();
		depth_req_t r;
		r = random_query();
		for (int t = 0; t < 64 && !reads_written(r); t++)
			r = random_query();
		if (!reads_written(r))
			r.sprite_x = LEFT_W'(SCR_W);
		return r;
	endfunction

	function automatic paced_req_t paced(depth_req_t body, pace_t pace);
		paced_req_t p;
		p.body = body;
		p.pace = pace;
		p.drain_first = 1'b0;
		p.hold_rx = 1'b0;
		return p;
	endfunction

	// Queue a request and note the column a store will write.
	task automatic enqueue(paced_req_t p);
		if (p.body.command == szbo_pkg::CMD_STORE && p.body.column < SCR_W)
			planned[p.body.column] = 1'b1;
		pending_reqs.push_back(p);
	endtask

	// Request driver: pops pending requests, holds each until accepted.
	always @(posedge clk or negedge arst_n) begin
		paced_req_t nxt;
		logic       free;
		logic       show;
		logic       kick;
		int unsigned idle_pct;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_req <= '0;
			hold_kick <= 1'b0;
			cur_pace <= PACE_FULL;
		end else begin
			kick = 1'b0;
			show = 1'b0;
			if (drv_valid && req_ch.ready)
				record_request(drv_req);
			free = !drv_valid || req_ch.ready;
			if (free && pending_reqs.size() != 0) begin
				nxt = pending_reqs[0];
				idle_pct = (nxt.pace == PACE_SRC_IDLE) ? 59 : (nxt.pace == PACE_BOTH) ? 30 : 0;
				if (!(nxt.drain_first && owed_spans.size() != 0)
						&& $urandom_range(99) >= idle_pct) begin
					void'(pending_reqs.pop_front());
					show = 1'b1;
					kick = nxt.hold_rx;
					drv_req <= nxt.body;
					cur_pace <= nxt.pace;
				end
			end
			if (free)
				drv_valid <= show;
			hold_kick <= kick;
		end
	end

	// Receiver hold-off counter.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_kick) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: compare each accepted span with the oldest owed one.
	always @(posedge clk or negedge arst_n) begin
		span_t got;
		span_t want;
		logic  rdy;
		int unsigned stall_pct;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ready) begin
				got.visible = rsp_ch.visible;
				got.tex_start = rsp_ch.tex_start;
				got.tex_end = rsp_ch.tex_end;
				if (owed_spans.size() == 0) begin
					report_fault($sformatf("unexpected result vis=%0b start=%0d end=%0d",
						got.visible, got.tex_start, got.tex_end));
				end else begin
					want = owed_spans.pop_front();
					if (got.visible !== want.visible || got.tex_start !== want.tex_start
							|| got.tex_end !== want.tex_end)
						report_fault($sformatf(
							{"span mismatch: exp vis=%0b start=%0d end=%0d,",
							" got vis=%0b start=%0d end=%0d"},
							want.visible, want.tex_start, want.tex_end,
							got.visible, got.tex_start, got.tex_end));
				end
			end
			stall_pct = (cur_pace == PACE_SNK_STALL) ? 59 : (cur_pace == PACE_BOTH) ? 30 : 0;
			rdy = (hold_left == 0) && ($urandom_range(99) >= stall_pct);
			rsp_ready <= rdy;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		paced_req_t p;
		// Both screen edges written first; queries only scan written columns.
		for (int c = 0; c < FILL_LO; c++)
			enqueue(paced(store_of(c, pick_depth()), PACE_FULL));
		for (int c = SCR_W - FILL_HI; c < SCR_W; c++)
			enqueue(paced(store_of(c, pick_depth()), PACE_FULL));

		// Depth extremes and out-of-range stores (dropped).
		enqueue(paced(store_of(0, '0), PACE_FULL));
		enqueue(paced(store_of(SCR_W - 1, '1), PACE_FULL));
		enqueue(paced(store_of(4095, '0), PACE_FULL));
		enqueue(paced(store_of(SCR_W, '0), PACE_FULL));
		// Zero width.
		enqueue(paced(query_of(5, 0, 100, '0), PACE_FULL));
		// Wholly off screen, left and right, at field extremes.
		enqueue(paced(query_of(-32768, 16383, 4095, '0), PACE_FULL));
		enqueue(paced(query_of(32767, 100, 64, '0), PACE_FULL));
		// Clipped on the left and on the right.
		enqueue(paced(query_of(-10, 30, 64, '0), PACE_FULL));
		enqueue(paced(query_of(SCR_W - 20, 50, 77, '0), PACE_FULL));
		// Full occlusion over a patch of near walls.
		for (int c = 10; c < 20; c++)
			enqueue(paced(store_of(c, 32'h0000_0100), PACE_FULL));
		enqueue(paced(query_of(10, 10, 50, 32'h0000_0200), PACE_FULL));
		// Equal depth counts as visible.
		enqueue(paced(store_of(30, 32'h1234_5678), PACE_FULL));
		enqueue(paced(query_of(30, 1, 4095, 32'h1234_5678), PACE_FULL));
		// Zero texture width with a visible column.
		enqueue(paced(query_of(0, 10, 0, '0), PACE_FULL));
		// Farthest sprite, long scans and very wide sprites clipped on either side.
		enqueue(paced(query_of(0, 64, 4095, '1), PACE_FULL));
		enqueue(paced(query_of(0, FILL_LO, 4095, '0), PACE_FULL));
		enqueue(paced(query_of(-16000, 16000 + FILL_LO, 4095, 32'h0008_0000), PACE_FULL));
		enqueue(paced(query_of(SCR_W - FILL_HI, 16383, 4095, '0), PACE_FULL));

		// Random phases, each opened by a drain; one long receiver hold-off.
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < RANDOM_PER_PACE; i++) begin
				p = paced(($urandom_range(99) < 40) ? random_store() : safe_query(),
					pace_t'(k));
				p.drain_first = (i == 0);
				if (k == 0 && i == 20) begin
					p.body = safe_query();
					p.hold_rx = 1'b1;
				end
				enqueue(p);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || drv_valid || owed_spans.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_cnt == 0 && owed_spans.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/szbo_pkg.sv
hdl/szbo_stream_if.sv
hdl/szbo_ctrl.sv
hdl/szbo_dp.sv
hdl/sprite_zbuffer_occlusion_span_core.sv
hdl/szbo_checker.sv
sim/sprite_zbuffer_occlusion_span_core_tb.sv
